>>> sv/icd_pkg.sv
// ----------------------------------------------------------------------------
// icd_pkg
// shared widths, operation and status codes, and controller/datapath structs
// ----------------------------------------------------------------------------
`default_nettype none

package icd_pkg;

    // fixed field widths of the stream payload
    localparam int KIND_W   = 4;
    localparam int IDX_W    = 9;
    localparam int ROT_W    = 10;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 9;

    // default sizing of the element store
    localparam int DEF_CAPACITY    = 256;
    localparam int DEF_VALUE_WIDTH = 32;

    // tdata widths, rounded up to whole bytes
    localparam int S_TDATA_W = ((IDX_W + ROT_W + DATA_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((DATA_W + COUNT_W + 7) / 8) * 8;

    typedef enum logic [KIND_W-1:0] {
        KIND_GET        = 4'd0,
        KIND_PUT        = 4'd1,
        KIND_INSERT     = 4'd2,
        KIND_PUSH_FRONT = 4'd3,
        KIND_PUSH_BACK  = 4'd4,
        KIND_REMOVE     = 4'd5,
        KIND_POP_FRONT  = 4'd6,
        KIND_POP_BACK   = 4'd7,
        KIND_ROTATE     = 4'd8
    } t_kind;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2,
        ST_EMPTY = 2'd3
    } t_status;

    // controller -> datapath
    typedef struct packed {
        logic in_ready;
        logic capture;
        logic plan;
        logic cap_old;
        logic mv_step;
        logic fin_wr;
        logic rd_new;
        logic cap_new;
        logic finish;
    } t_ctrl_cmd;

    // datapath -> controller
    typedef struct packed {
        logic ok;
        logic has_moves;
        logic last_move;
        logic out_busy;
    } t_dp_stat;

endpackage

`default_nettype wire

>>> sv/icd_ctrl.sv
// ----------------------------------------------------------------------------
// icd_ctrl
// sequencer for one deque operation: plan, old read, element moves, final
// write, new read and result hand-off
// ----------------------------------------------------------------------------
`default_nettype none

module icd_ctrl
    import icd_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    input  wire t_dp_stat  i_stat,
    output t_ctrl_cmd      o_cmd
);

    typedef enum logic [9:0] {
        S_IDLE    = 10'b00_0000_0001,
        S_PLAN    = 10'b00_0000_0010,
        S_RD_OLD  = 10'b00_0000_0100,
        S_CAP_OLD = 10'b00_0000_1000,
        S_MOVE    = 10'b00_0001_0000,
        S_DRAIN   = 10'b00_0010_0000,
        S_FIN     = 10'b00_0100_0000,
        S_RD_NEW  = 10'b00_1000_0000,
        S_CAP_NEW = 10'b01_0000_0000,
        S_DONE    = 10'b10_0000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_PLAN;
                end
            end
            S_PLAN: begin
                o_cmd.plan = 1'b1;
                n_state    = S_RD_OLD;
            end
            // read address was set up by the plan
            S_RD_OLD: begin
                n_state = S_CAP_OLD;
            end
            S_CAP_OLD: begin
                o_cmd.cap_old = 1'b1;
                priority if (!i_stat.ok) begin
                    n_state = S_DONE;
                end else if (i_stat.has_moves) begin
                    n_state = S_MOVE;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_MOVE: begin
                o_cmd.mv_step = 1'b1;
                if (i_stat.last_move) begin
                    n_state = S_DRAIN;
                end
            end
            // last moved element is written here
            S_DRAIN: begin
                n_state = S_FIN;
            end
            S_FIN: begin
                o_cmd.fin_wr = 1'b1;
                n_state      = S_RD_NEW;
            end
            S_RD_NEW: begin
                o_cmd.rd_new = 1'b1;
                n_state      = S_CAP_NEW;
            end
            S_CAP_NEW: begin
                o_cmd.cap_new = 1'b1;
                n_state       = S_DONE;
            end
            S_DONE: begin
                if (!i_stat.out_busy) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

>>> sv/icd_datapath.sv
// ----------------------------------------------------------------------------
// icd_datapath
// ring store, head and count, operation planner, move pointers and the
// output register
// ----------------------------------------------------------------------------
`default_nettype none

module icd_datapath
    import icd_pkg::*;
#(
    parameter int CAPACITY    = DEF_CAPACITY,
    parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_ctrl_cmd             i_cmd,
    input  wire logic [S_TDATA_W-1:0]  i_in_tdata,
    input  wire logic [KIND_W-1:0]     i_in_tuser,
    input  wire logic                  i_out_ready,
    output logic                       o_out_valid,
    output logic [M_TDATA_W-1:0]       o_out_tdata,
    output logic [STATUS_W-1:0]        o_out_tuser,
    output t_dp_stat                   o_stat
);

    localparam int AW  = $clog2(CAPACITY);
    localparam int CW  = $clog2(CAPACITY + 1);
    localparam int SW  = CW + 1;
    localparam int XW  = ((CW > IDX_W) ? CW : IDX_W) + 1;
    localparam int AXW = ((CW > ROT_W) ? CW : ROT_W) + 2;

    // (a + k) mod capacity, a below capacity, k at most capacity
    function automatic logic [AW-1:0] add_mod(input logic [AW-1:0] a,
                                              input logic [CW-1:0] k);
        logic [SW-1:0] s;
        s = SW'(a) + SW'(k);
        if (s >= SW'(CAPACITY)) begin
            s = s - SW'(CAPACITY);
        end
        return AW'(s);
    endfunction

    // (a - k) mod capacity, k at most capacity
    function automatic logic [AW-1:0] sub_mod(input logic [AW-1:0] a,
                                              input logic [CW-1:0] k);
        logic [SW-1:0] s;
        if (SW'(a) >= SW'(k)) begin
            s = SW'(a) - SW'(k);
        end else begin
            s = SW'(a) + SW'(CAPACITY) - SW'(k);
        end
        return AW'(s);
    endfunction

    // captured item
    logic [KIND_W-1:0]        r_kind;
    logic [IDX_W-1:0]         r_index;
    logic signed [ROT_W-1:0]  r_amount;
    logic [DATA_W-1:0]        r_data_in;

    // architectural state
    logic [AW-1:0]            r_head;
    logic [CW-1:0]            r_count;

    // plan
    logic [STATUS_W-1:0]      r_status,  n_status;
    logic                     r_ok,      n_ok;
    logic                     r_pre_rd,  n_pre_rd;
    logic [AW-1:0]            r_rd_addr, n_rd_addr;
    logic                     r_fin_we,  n_fin_we;
    logic [AW-1:0]            r_fin_addr, n_fin_addr;
    logic                     r_post_rd, n_post_rd;
    logic [CW-1:0]            r_moves,   n_moves;
    logic [AW-1:0]            r_src,     n_src;
    logic [AW-1:0]            r_dst,     n_dst;
    logic                     r_dir_up,  n_dir_up;
    logic [AW-1:0]            r_head_nx, n_head_nx;
    logic [CW-1:0]            r_count_nx, n_count_nx;
    logic [DATA_W-1:0]        r_res,     n_res;

    // memory pipeline
    logic [VALUE_WIDTH-1:0]   r_mem [CAPACITY];
    logic [VALUE_WIDTH-1:0]   r_rd_data;
    logic                     r_wp;
    logic [AW-1:0]            r_wa;
    logic                     mem_we;
    logic [AW-1:0]            mem_wa;
    logic [AW-1:0]            mem_ra;
    logic [VALUE_WIDTH-1:0]   mem_wd;

    // output register
    logic                     r_ovalid;
    logic [DATA_W-1:0]        r_o_data;
    logic [STATUS_W-1:0]      r_o_status;
    logic [COUNT_W-1:0]       r_o_count;

    logic [VALUE_WIDTH-1:0]   word_v;
    logic [DATA_W-1:0]        word_d;
    logic [DATA_W-1:0]        rd_word;

    // word_d is the incoming word as the store keeps it, seen on the result field
    generate
        if (VALUE_WIDTH >= DATA_W) begin : g_wide
            assign word_v  = VALUE_WIDTH'(r_data_in);
            assign word_d  = r_data_in;
            assign rd_word = r_rd_data[DATA_W-1:0];
        end else begin : g_narrow
            assign word_v  = r_data_in[VALUE_WIDTH-1:0];
            assign word_d  = DATA_W'(word_v);
            assign rd_word = DATA_W'(r_rd_data);
        end
    endgenerate

    // planner operands
    logic [CW-1:0]            idx_c;
    logic [XW-1:0]            idx_x;
    logic [XW-1:0]            n_x;
    logic [CW-1:0]            n_m1;
    logic [AW-1:0]            sl_idx, sl_idxp1, sl_idxm1, sl_n, sl_nm1, h_p1, h_m1;
    logic [AW-1:0]            ins_fin;
    logic                     is_empty, is_full;
    logic signed [AXW-1:0]    amt_x, n_sx, a_pos;
    logic                     rot_bad;
    logic [CW-1:0]            a_c, rot_s, rot_r;
    logic [AW-1:0]            sl_s, h_mr;

    assign idx_c    = CW'(r_index);
    assign idx_x    = XW'(r_index);
    assign n_x      = XW'(r_count);
    assign n_m1     = r_count - CW'(1);
    assign is_empty = (r_count == '0);
    assign is_full  = (n_x == XW'(CAPACITY));

    assign sl_idx   = add_mod(r_head, idx_c);
    assign sl_idxp1 = add_mod(r_head, idx_c + CW'(1));
    assign sl_idxm1 = add_mod(r_head, idx_c - CW'(1));
    assign sl_n     = add_mod(r_head, r_count);
    assign sl_nm1   = add_mod(r_head, n_m1);
    assign h_p1     = add_mod(r_head, CW'(1));
    assign h_m1     = sub_mod(r_head, CW'(1));
    // front-side insert lands one slot before the old element at index
    assign ins_fin  = (r_index == '0) ? h_m1 : sl_idxm1;

    // rotate amount folded into 0 .. count-1
    assign amt_x   = AXW'(r_amount);
    assign n_sx    = signed'(AXW'(r_count));
    assign rot_bad = (amt_x > n_sx) || (amt_x < -n_sx);
    assign a_pos   = (amt_x < 0) ? amt_x + n_sx : amt_x;
    assign a_c     = a_pos[CW-1:0];
    assign rot_s   = (a_c == r_count) ? '0 : a_c;
    assign rot_r   = r_count - rot_s;
    assign sl_s    = add_mod(r_head, rot_s);
    assign h_mr    = sub_mod(r_head, rot_r);

    always_comb begin
        n_status   = ST_OK;
        n_ok       = 1'b1;
        n_pre_rd   = 1'b0;
        n_rd_addr  = sl_idx;
        n_fin_we   = 1'b0;
        n_fin_addr = sl_idx;
        n_post_rd  = 1'b0;
        n_moves    = '0;
        n_src      = r_head;
        n_dst      = r_head;
        n_dir_up   = 1'b1;
        n_head_nx  = r_head;
        n_count_nx = r_count;
        n_res      = '0;
        unique case (t_kind'(r_kind))
            KIND_GET, KIND_PUT, KIND_REMOVE: begin
                priority if (is_empty) begin
                    n_status = ST_EMPTY;
                    n_ok     = 1'b0;
                end else if (idx_x >= n_x) begin
                    n_status = ST_RANGE;
                    n_ok     = 1'b0;
                end else begin
                    n_pre_rd = 1'b1;
                    if (t_kind'(r_kind) == KIND_PUT) begin
                        n_fin_we = 1'b1;
                    end
                    if (t_kind'(r_kind) == KIND_REMOVE) begin
                        n_count_nx = n_m1;
                        // close the gap from the shorter side
                        if (idx_c < n_m1 - idx_c) begin
                            n_moves   = idx_c;
                            n_src     = sl_idxm1;
                            n_dst     = sl_idx;
                            n_dir_up  = 1'b0;
                            n_head_nx = h_p1;
                        end else begin
                            n_moves = n_m1 - idx_c;
                            n_src   = sl_idxp1;
                            n_dst   = sl_idx;
                        end
                    end
                end
            end
            KIND_INSERT: begin
                priority if (idx_x > n_x) begin
                    n_status = ST_RANGE;
                    n_ok     = 1'b0;
                end else if (is_full) begin
                    n_status = ST_FULL;
                    n_ok     = 1'b0;
                end else begin
                    n_fin_we   = 1'b1;
                    n_count_nx = r_count + CW'(1);
                    n_res      = word_d;
                    // open the gap on the shorter side
                    if (idx_c <= r_count - idx_c) begin
                        n_moves    = idx_c;
                        n_src      = r_head;
                        n_dst      = h_m1;
                        n_head_nx  = h_m1;
                        n_fin_addr = ins_fin;
                    end else begin
                        n_moves    = r_count - idx_c;
                        n_src      = sl_nm1;
                        n_dst      = sl_n;
                        n_dir_up   = 1'b0;
                        n_fin_addr = sl_idx;
                    end
                end
            end
            KIND_PUSH_FRONT, KIND_PUSH_BACK: begin
                if (is_full) begin
                    n_status = ST_FULL;
                    n_ok     = 1'b0;
                end else begin
                    n_fin_we   = 1'b1;
                    n_count_nx = r_count + CW'(1);
                    n_res      = word_d;
                    if (t_kind'(r_kind) == KIND_PUSH_FRONT) begin
                        n_head_nx  = h_m1;
                        n_fin_addr = h_m1;
                    end else begin
                        n_fin_addr = sl_n;
                    end
                end
            end
            KIND_POP_FRONT, KIND_POP_BACK: begin
                if (is_empty) begin
                    n_status = ST_EMPTY;
                    n_ok     = 1'b0;
                end else begin
                    n_pre_rd   = 1'b1;
                    n_count_nx = n_m1;
                    if (t_kind'(r_kind) == KIND_POP_FRONT) begin
                        n_rd_addr = r_head;
                        n_head_nx = h_p1;
                    end else begin
                        n_rd_addr = sl_nm1;
                    end
                end
            end
            KIND_ROTATE: begin
                priority if (is_empty) begin
                    n_status = ST_EMPTY;
                    n_ok     = 1'b0;
                end else if (rot_bad) begin
                    n_status = ST_RANGE;
                    n_ok     = 1'b0;
                end else begin
                    n_post_rd = 1'b1;
                    priority if (is_full) begin
                        // full ring: rotation is a pure head move
                        n_head_nx = sl_s;
                    end else if (rot_s <= rot_r) begin
                        // carry front elements round to the back
                        n_moves   = rot_s;
                        n_src     = r_head;
                        n_dst     = sl_n;
                        n_head_nx = sl_s;
                    end else begin
                        // carry back elements round to the front
                        n_moves   = rot_r;
                        n_src     = sl_nm1;
                        n_dst     = h_m1;
                        n_dir_up  = 1'b0;
                        n_head_nx = h_mr;
                    end
                end
            end
            default: begin
                n_status = ST_OK;
            end
        endcase
    end

    // memory ports
    assign mem_we = r_wp || (i_cmd.fin_wr && r_fin_we);
    assign mem_wa = r_wp ? r_wa : r_fin_addr;
    assign mem_wd = r_wp ? r_rd_data : word_v;
    assign mem_ra = i_cmd.mv_step ? r_src : (i_cmd.rd_new ? r_head_nx : r_rd_addr);

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        r_rd_data <= r_mem[mem_ra];
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_kind    <= i_in_tuser;
            r_index   <= i_in_tdata[IDX_W-1:0];
            r_amount  <= i_in_tdata[IDX_W+ROT_W-1:IDX_W];
            r_data_in <= i_in_tdata[IDX_W+ROT_W+DATA_W-1:IDX_W+ROT_W];
        end
        if (i_cmd.plan) begin
            r_status   <= n_status;
            r_ok       <= n_ok;
            r_pre_rd   <= n_pre_rd;
            r_rd_addr  <= n_rd_addr;
            r_fin_we   <= n_fin_we;
            r_fin_addr <= n_fin_addr;
            r_post_rd  <= n_post_rd;
            r_dir_up   <= n_dir_up;
            r_head_nx  <= n_head_nx;
            r_count_nx <= n_count_nx;
        end
        priority if (i_cmd.plan) begin
            r_moves <= n_moves;
            r_src   <= n_src;
            r_dst   <= n_dst;
        end else if (i_cmd.mv_step) begin
            r_moves <= r_moves - CW'(1);
            r_src   <= r_dir_up ? add_mod(r_src, CW'(1)) : sub_mod(r_src, CW'(1));
            r_dst   <= r_dir_up ? add_mod(r_dst, CW'(1)) : sub_mod(r_dst, CW'(1));
        end
        if (i_cmd.mv_step) begin
            r_wa <= r_dst;
        end
        priority if (i_cmd.plan) begin
            r_res <= n_res;
        end else if ((i_cmd.cap_old && r_pre_rd) || (i_cmd.cap_new && r_post_rd)) begin
            r_res <= rd_word;
        end
        if (i_cmd.finish) begin
            r_o_data   <= r_res;
            r_o_status <= r_status;
            r_o_count  <= COUNT_W'(r_count_nx);
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head   <= '0;
            r_count  <= '0;
            r_wp     <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_wp <= i_cmd.mv_step;
            if (i_cmd.finish) begin
                r_head   <= r_head_nx;
                r_count  <= r_count_nx;
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_out_tdata = M_TDATA_W'({r_o_count, r_o_data});
    assign o_out_tuser = r_o_status;

    assign o_stat.ok        = r_ok;
    assign o_stat.has_moves = (r_moves != '0);
    assign o_stat.last_move = (r_moves == CW'(1));
    assign o_stat.out_busy  = r_ovalid && !i_out_ready;

endmodule

`default_nettype wire

>>> sv/indexed_circular_deque.sv
// ----------------------------------------------------------------------------
// indexed_circular_deque
// bounded ring of words with indexed get, put, insert, remove, push, pop and
// rotate, one operation per input transaction, one result per operation
// ----------------------------------------------------------------------------
// Each input transaction carries one operation and produces exactly one result
// transaction with the affected word, a status code and the element count
// after the operation. Operations run one at a time: s_axis_tready is high
// only while the block is idle, but a finished result sits in an output
// register so the next operation is taken while the previous result is still
// waiting on m_axis. Get, put, push and pop pass from capture through the
// plan, old read, final write and new read to the result hand-off. Insert,
// remove and rotate also move stored elements one per cycle through the
// store's single write port between the old read and the final write; the
// planner always shifts the shorter side, so moves never exceed CAPACITY/2
// (rotating a full store is a head move only). A failed operation returns a
// zero word and leaves the state as it was. The store has no reset; slots
// outside the current count hold stale words and are never returned.
// ----------------------------------------------------------------------------
`default_nettype none

module indexed_circular_deque
    import icd_pkg::*;
#(
    parameter int CAPACITY    = DEF_CAPACITY,
    parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,

    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // index [8:0], rotate_amount [18:9], data_in [50:19], zero pad above
    input  wire logic [S_TDATA_W-1:0]  s_axis_tdata,
    // kind [3:0]
    input  wire logic [KIND_W-1:0]     s_axis_tuser,

    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // data_out [31:0], count [40:32], zero pad above
    output logic [M_TDATA_W-1:0]       m_axis_tdata,
    // status [1:0]
    output logic [STATUS_W-1:0]        m_axis_tuser
);

    t_ctrl_cmd cmd;
    t_dp_stat  stat;

    // sequencer: one operation from capture to result hand-off
    icd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // store, planner, move pointers and output register
    icd_datapath #(
        .CAPACITY    (CAPACITY),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_in_tdata  (s_axis_tdata),
        .i_in_tuser  (s_axis_tuser),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_tdata (m_axis_tdata),
        .o_out_tuser (m_axis_tuser),
        .o_stat      (stat)
    );

    // input side is open only while the sequencer is idle
    assign s_axis_tready = cmd.in_ready;

`ifndef SYNTHESIS
    // the sequencer captures exactly on an input transaction
    a_capture_on_handshake: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        cmd.capture == (s_axis_tvalid && s_axis_tready)
    ) else $error("capture does not match input transaction");

    // a new result never overwrites one still stalled on the output
    a_no_result_overwrite: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        cmd.finish |-> !(m_axis_tvalid && !m_axis_tready)
    ) else $error("result overwritten while stalled");

    // a failed operation reports a zero word
    a_error_zero_word: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser != ST_OK)) |-> (m_axis_tdata[DATA_W-1:0] == '0)
    ) else $error("failed operation returned a nonzero word");

    // element moves only run while the plan still has moves left
    a_moves_bounded: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        cmd.mv_step |-> stat.has_moves
    ) else $error("move step issued with no moves pending");
`endif

endmodule

`default_nettype wire
